[hdl/scwr_pkg.sv]
// Package for the sigma clipped window resampler.
// Holds field widths, request and register codes and the sequencer state type.
// No dependencies.
package scwr_pkg;

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 24;
    localparam int ENTRY_W = 25;
    localparam int HW_W    = 31;
    localparam int THR_W   = 12;
    localparam int T2_W    = 24;
    localparam int CIU_W   = 2;
    localparam int ADDR_W  = 2;
    localparam int BUS_W   = 112;

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [ADDR_W-1:0] REG_HALF_WINDOW = 2'd0;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_COMPONENTS  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WF_RD,
        S_WF_CHK,
        S_END_RD,
        S_END_CHK,
        S_WIN,
        S_COMP,
        S_P1_RD,
        S_P1_ACC,
        S_P1_DIV,
        S_P2_RD,
        S_P2_SQ,
        S_P2_ACC,
        S_P2_MUL,
        S_P3_RD,
        S_P3_SQ,
        S_P3_MST,
        S_P3_MUL,
        S_P3_DIV,
        S_NEXT,
        S_DONE
    } state_t;

endpackage

[hdl/scwr_div.sv]
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on scwr_pkg.
module scwr_div #(
    parameter int SW = 35,
    parameter int CW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SW-1:0]          dividend,
    input  logic [CW-1:0]                 divisor,
    output logic                          done,
    output logic signed [scwr_pkg::VAL_W-1:0] quot
);
    import scwr_pkg::*;

    localparam int NW = $clog2(SW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [SW-1:0] quo_reg, quo_next;
    logic [CW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [CW:0]   trial;
    logic [SW-1:0] signed_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[SW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = NW'(SW);
            rem_next  = '0;
            neg_next  = dividend[SW-1];
            quo_next  = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = CW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign signed_q = neg_reg ? SW'(-quo_reg) : quo_reg;
    assign quot     = signed_q[VAL_W-1:0];
    assign done     = done_reg;

endmodule

[hdl/scwr_mul.sv]
// Serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on scwr_pkg.
module scwr_mul #(
    parameter int RW  = 83,
    parameter int MBW = 27
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [RW-1:0]  a,
    input  logic [MBW-1:0] b,
    output logic           done,
    output logic [RW-1:0]  prod
);
    import scwr_pkg::*;

    localparam int NW = $clog2(MBW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic [RW-1:0]  a_reg, a_next;
    logic [MBW-1:0] b_reg, b_next;
    logic [RW-1:0]  acc_reg, acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = NW'(MBW);
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[RW-2:0], 1'b0};
            b_next   = {1'b0, b_reg[MBW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[hdl/sigma_clipped_window_resampler_unit.sv]
// Top level of the sigma clipped window resampler: sample memories and query sequencer.
// Depends on scwr_pkg, scwr_div and scwr_mul.
// Store and clear requests are handled in the idle state; a query request is worked on
// alone, as new requests are taken only in the idle state. A query steps past and scans
// the stored samples through the single read port of the sample memories to find its
// window of n samples, then per active component sums the window and divides by n in the
// serial divider. With clipping on, it also sums the squared deviations, scales them in
// one serial multiply, runs n such multiplies for the per-sample test and divides once more.
// A finished result waits in the output register while new requests are taken.
module sigma_clipped_window_resampler_unit #(
    parameter int DEPTH      = 1024,
    parameter int COMPONENTS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // time_req, value_a, value_b, value_c, valid_a, valid_b, valid_c, zero fill
    input  logic [scwr_pkg::BUS_W-1:0]    s_tdata,
    // mode
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ref_time, mean_a, mean_b, mean_c, ok_a, ok_b, ok_c, zero fill
    output logic [scwr_pkg::BUS_W-1:0]    m_tdata,
    input  logic                          cfg_we,
    input  logic [scwr_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [scwr_pkg::HW_W-1:0]     cfg_wdata
);
    import scwr_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(DEPTH);
    localparam int SW  = VAL_W + CW;
    localparam int SQW = 2 * VAL_W + CW;
    localparam int RW  = SQW + T2_W;
    localparam int MBW = (CW + 16 > T2_W) ? CW + 16 : T2_W;

    typedef logic [COMPONENTS-1:0][ENTRY_W-1:0] row_t;

    logic [TIME_W-1:0] tmem [DEPTH];
    row_t              vmem [DEPTH];
    logic [TIME_W-1:0] t_q;
    row_t              row_q;
    row_t              row_in;
    logic [AW-1:0]     raddr;

    state_t state_reg, state_next;

    logic [HW_W-1:0]  hw_reg;
    logic [THR_W-1:0] thr_reg;
    logic [CIU_W-1:0] ciu_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] wf_reg, wf_next;
    logic [CW-1:0] wend_reg, wend_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic [1:0]    comp_reg, comp_next;

    logic [TIME_W-1:0]     tref_reg, tref_next;
    logic signed [33:0]    lo_reg, lo_next;
    logic signed [33:0]    hi_reg, hi_next;
    logic signed [SW-1:0]  sum_reg, sum_next;
    logic signed [SW-1:0]  psum_reg, psum_next;
    logic                  bad_reg, bad_next;
    logic signed [VAL_W-1:0] mean_reg, mean_next;
    logic [SQW-1:0]        ssq_reg, ssq_next;
    logic [2*VAL_W-1:0]    dd_reg, dd_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [2:0][VAL_W-1:0] res_reg, res_next;
    logic [2:0]            ok_reg, ok_next;

    logic             out_valid_reg, out_valid_next;
    logic [BUS_W-1:0] out_data_reg, out_data_next;

    logic               in_acc;
    logic               mem_we;
    logic [1:0]         mode;
    logic [1:0]         active;
    logic [ENTRY_W-1:0] entry;
    logic signed [VAL_W-1:0] x_val;
    logic signed [VAL_W:0]   d_val;
    logic signed [2*VAL_W+1:0] dd_full;
    logic signed [33:0] tq_ext;
    logic signed [33:0] tin_ext;
    logic [T2_W-1:0]    t2;
    logic [MBW-1:0]     k_val;

    logic              div_start, div_done;
    logic signed [SW-1:0] div_num;
    logic [CW-1:0]     div_den;
    logic signed [VAL_W-1:0] div_q;
    logic              mul_start, mul_done;
    logic [RW-1:0]     mul_a, mul_prod;
    logic [MBW-1:0]    mul_b;

    assign mode     = s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign mem_we   = in_acc && (mode == MODE_STORE) && (count_reg < CW'(DEPTH));

    always_comb
    begin
        logic [2:0][ENTRY_W-1:0] all_in;
        all_in[0] = {s_tdata[104], s_tdata[55:32]};
        all_in[1] = {s_tdata[105], s_tdata[79:56]};
        all_in[2] = {s_tdata[106], s_tdata[103:80]};
        for (int c = 0; c < COMPONENTS; c++)
        begin
            row_in[c] = all_in[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tmem[count_reg[AW-1:0]] <= s_tdata[TIME_W-1:0];
            vmem[count_reg[AW-1:0]] <= row_in;
        end
        t_q   <= tmem[raddr];
        row_q <= vmem[raddr];
    end

    always_comb
    begin
        priority case (state_reg)
            S_WF_RD:  raddr = wf_reg[AW-1:0];
            S_END_RD: raddr = wend_reg[AW-1:0];
            default:  raddr = idx_reg[AW-1:0];
        endcase
    end

    assign active  = (ciu_reg > 2'(COMPONENTS)) ? 2'(COMPONENTS) : ciu_reg;
    assign entry   = (comp_reg < 2'(COMPONENTS)) ? row_q[comp_reg] : '0;
    assign x_val   = entry[VAL_W-1:0];
    assign d_val   = {x_val[VAL_W-1], x_val} - {mean_reg[VAL_W-1], mean_reg};
    assign dd_full = d_val * d_val;
    assign tq_ext  = {{2{t_q[TIME_W-1]}}, t_q};
    assign tin_ext = {{2{s_tdata[TIME_W-1]}}, s_tdata[TIME_W-1:0]};
    assign t2      = {{(T2_W-THR_W){1'b0}}, thr_reg} * {{(T2_W-THR_W){1'b0}}, thr_reg};
    assign k_val   = MBW'({n_reg - 1'b1, 16'd0});

    scwr_div #(.SW(SW), .CW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quot     (div_q)
    );

    scwr_mul #(.RW(RW), .MBW(MBW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hw_reg        <= '0;
            thr_reg       <= '0;
            ciu_reg       <= CIU_W'(1);
            count_reg     <= '0;
            wf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wf_reg        <= wf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                priority case (cfg_addr)
                    REG_HALF_WINDOW: hw_reg  <= cfg_wdata;
                    REG_THRESHOLD:   thr_reg <= cfg_wdata[THR_W-1:0];
                    REG_COMPONENTS:  ciu_reg <= cfg_wdata[CIU_W-1:0];
                    default:         hw_reg  <= hw_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wend_reg     <= wend_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        pc_reg       <= pc_next;
        comp_reg     <= comp_next;
        tref_reg     <= tref_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        sum_reg      <= sum_next;
        psum_reg     <= psum_next;
        bad_reg      <= bad_next;
        mean_reg     <= mean_next;
        ssq_reg      <= ssq_next;
        dd_reg       <= dd_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        res_reg      <= res_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wf_next        = wf_reg;
        wend_next      = wend_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        pc_next        = pc_reg;
        comp_next      = comp_reg;
        tref_next      = tref_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        psum_next      = psum_reg;
        bad_next       = bad_reg;
        mean_next      = mean_reg;
        ssq_next       = ssq_reg;
        dd_next        = dd_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        res_next       = res_reg;
        ok_next        = ok_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        div_num        = sum_reg;
        div_den        = n_reg;
        mul_start      = 1'b0;
        mul_a          = RW'(ssq_reg);
        mul_b          = MBW'(t2);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (mode == MODE_STORE)
                    begin
                        if (mem_we)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (mode == MODE_CLEAR)
                    begin
                        count_next = '0;
                        wf_next    = '0;
                    end
                    else if (mode == MODE_QUERY)
                    begin
                        tref_next  = s_tdata[TIME_W-1:0];
                        lo_next    = tin_ext - $signed({3'd0, hw_reg});
                        hi_next    = tin_ext + $signed({3'd0, hw_reg});
                        res_next   = '0;
                        ok_next    = '0;
                        state_next = S_WF_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WF_RD:
            begin
                if (wf_reg < count_reg)
                begin
                    state_next = S_WF_CHK;
                end
                else
                begin
                    wend_next  = wf_reg;
                    state_next = S_END_RD;
                end
            end
            S_WF_CHK:
            begin
                if (tq_ext <= lo_reg)
                begin
                    wf_next    = wf_reg + 1'b1;
                    state_next = S_WF_RD;
                end
                else
                begin
                    wend_next  = wf_reg;
                    state_next = S_END_RD;
                end
            end
            S_END_RD:
            begin
                state_next = (wend_reg < count_reg) ? S_END_CHK : S_WIN;
            end
            S_END_CHK:
            begin
                if (tq_ext <= hi_reg)
                begin
                    wend_next  = wend_reg + 1'b1;
                    state_next = S_END_RD;
                end
                else
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                n_next    = wend_reg - wf_reg;
                comp_next = '0;
                state_next = (wend_reg == wf_reg) ? S_DONE : S_COMP;
            end
            S_COMP:
            begin
                idx_next = wf_reg;
                sum_next = '0;
                bad_next = 1'b0;
                state_next = (comp_reg < active) ? S_P1_RD : S_DONE;
            end
            S_P1_RD:
            begin
                if (idx_reg < wend_reg)
                begin
                    state_next = S_P1_ACC;
                end
                else if (bad_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_P1_DIV;
                end
            end
            S_P1_ACC:
            begin
                if (!entry[VAL_W])
                begin
                    bad_next = 1'b1;
                end
                sum_next   = sum_reg + SW'(x_val);
                idx_next   = idx_reg + 1'b1;
                state_next = S_P1_RD;
            end
            S_P1_DIV:
            begin
                if (div_done)
                begin
                    mean_next = div_q;
                    idx_next  = wf_reg;
                    ssq_next  = '0;
                    if ((thr_reg == '0) || (n_reg == CW'(1)))
                    begin
                        res_next[comp_reg] = div_q;
                        ok_next[comp_reg]  = 1'b1;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_P2_RD;
                    end
                end
            end
            S_P2_RD:
            begin
                if (idx_reg < wend_reg)
                begin
                    state_next = S_P2_SQ;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_P2_MUL;
                end
            end
            S_P2_SQ:
            begin
                dd_next    = dd_full[2*VAL_W-1:0];
                state_next = S_P2_ACC;
            end
            S_P2_ACC:
            begin
                ssq_next   = ssq_reg + SQW'(dd_reg);
                idx_next   = idx_reg + 1'b1;
                state_next = S_P2_RD;
            end
            S_P2_MUL:
            begin
                if (mul_done)
                begin
                    r_next     = mul_prod;
                    idx_next   = wf_reg;
                    psum_next  = '0;
                    pc_next    = '0;
                    state_next = S_P3_RD;
                end
            end
            S_P3_RD:
            begin
                div_num = psum_reg;
                div_den = pc_reg;
                if (idx_reg < wend_reg)
                begin
                    state_next = S_P3_SQ;
                end
                else if (pc_reg == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_P3_DIV;
                end
            end
            S_P3_SQ:
            begin
                dd_next    = dd_full[2*VAL_W-1:0];
                x_next     = x_val;
                state_next = S_P3_MST;
            end
            S_P3_MST:
            begin
                mul_start  = 1'b1;
                mul_a      = RW'(dd_reg);
                mul_b      = k_val;
                state_next = S_P3_MUL;
            end
            S_P3_MUL:
            begin
                if (mul_done)
                begin
                    if (mul_prod <= r_reg)
                    begin
                        psum_next = psum_reg + SW'(x_reg);
                        pc_next   = pc_reg + 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_P3_RD;
                end
            end
            S_P3_DIV:
            begin
                if (div_done)
                begin
                    res_next[comp_reg] = div_q;
                    ok_next[comp_reg]  = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                comp_next  = comp_reg + 1'b1;
                state_next = S_COMP;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {5'd0, ok_reg[2], ok_reg[1], ok_reg[0],
                                      res_reg[2], res_reg[1], res_reg[0], tref_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[tb/sigma_clipped_window_resampler_unit_test.sv]
// Self-checking testbench for sigma_clipped_window_resampler_unit.
// It predicts each windowed, clipped mean in SystemVerilog and compares it with every response.
// Depends on scwr_pkg and the unit under test.
module sigma_clipped_window_resampler_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import scwr_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int NUM_COMP    = 3;

    typedef struct {
        logic [1:0]        mode;
        logic signed [31:0] tstamp;
        logic [23:0]       val [3];
        logic              vld [3];
    } request_t;

    typedef struct {
        logic [31:0] ref_time;
        logic [23:0] mean [3];
        logic        ok [3];
    } window_mean_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BUS_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [BUS_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [HW_W-1:0] cfg_wdata = '0;

    request_t     pending_reqs[$];
    window_mean_t expected_means[$];
    request_t     req_on_bus;
    int           send_gap = 0;
    int           mismatches = 0;
    int           stalls_asked = 0;
    int           stalls_done = 0;
    int           stall_left = 0;
    int           resp_gap = 0;

    logic [30:0] cur_half_window = '0;
    logic [11:0] cur_threshold = '0;
    logic [1:0]  cur_components = 2'd1;

    logic signed [31:0] pred_times [STORE_DEPTH];
    logic [23:0]        pred_vals [NUM_COMP][STORE_DEPTH];
    logic               pred_vlds [NUM_COMP][STORE_DEPTH];
    int unsigned        pred_count = 0;
    int unsigned        pred_first = 0;

    sigma_clipped_window_resampler_unit #(
        .DEPTH     (STORE_DEPTH),
        .COMPONENTS(NUM_COMP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void component_mean(input int c, input int unsigned first,
                                           input int unsigned last, output logic ok,
                                           output logic [23:0] mean_out);
        longint      sum;
        longint      avg;
        longint      dev;
        longint      kept_sum;
        longint      n;
        int unsigned kept;
        logic [63:0] ssq;
        logic [63:0] t2;
        logic [63:0] scale;
        logic [127:0] rhs;
        logic [127:0] lhs;
        sum = 0;
        ssq = '0;
        kept_sum = 0;
        kept = 0;
        n = longint'(last - first);
        ok = 1'b0;
        mean_out = '0;
        for (int unsigned i = first; i < last; i++)
        begin
            if (!pred_vlds[c][i])
                return;
            sum += longint'($signed(pred_vals[c][i]));
        end
        avg = sum / n;
        if (cur_threshold == 0 || n == 1)
        begin
            ok = 1'b1;
            mean_out = avg[23:0];
            return;
        end
        for (int unsigned i = first; i < last; i++)
        begin
            dev = longint'($signed(pred_vals[c][i])) - avg;
            ssq += 64'(dev * dev);
        end
        t2 = 64'(cur_threshold) * 64'(cur_threshold);
        scale = 64'(n - 1) << 16;
        rhs = {64'd0, ssq} * {64'd0, t2};
        for (int unsigned i = first; i < last; i++)
        begin
            dev = longint'($signed(pred_vals[c][i])) - avg;
            lhs = {64'd0, 64'(dev * dev)} * {64'd0, scale};
            if (lhs <= rhs)
            begin
                kept_sum += longint'($signed(pred_vals[c][i]));
                kept++;
            end
        end
        if (kept == 0)
            return;
        avg = kept_sum / longint'(kept);
        ok = 1'b1;
        mean_out = avg[23:0];
    endfunction

    function automatic void predict_request(input request_t r);
        window_mean_t res;
        longint       lo_edge;
        longint       hi_edge;
        int unsigned  last;
        int unsigned  active;
        if (r.mode == MODE_STORE)
        begin
            if (pred_count < STORE_DEPTH)
            begin
                pred_times[pred_count] = r.tstamp;
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    pred_vals[c][pred_count] = r.val[c];
                    pred_vlds[c][pred_count] = r.vld[c];
                end
                pred_count++;
            end
            return;
        end
        if (r.mode == MODE_CLEAR)
        begin
            pred_count = 0;
            pred_first = 0;
            return;
        end
        if (r.mode != MODE_QUERY)
            return;
        res.ref_time = r.tstamp;
        for (int c = 0; c < 3; c++)
        begin
            res.mean[c] = '0;
            res.ok[c] = 1'b0;
        end
        lo_edge = longint'(r.tstamp) - longint'(cur_half_window);
        hi_edge = longint'(r.tstamp) + longint'(cur_half_window);
        while (pred_first < pred_count && longint'(pred_times[pred_first]) <= lo_edge)
            pred_first++;
        if (pred_first < pred_count && longint'(pred_times[pred_first]) <= hi_edge)
        begin
            last = pred_first;
            while (last < pred_count && longint'(pred_times[last]) <= hi_edge)
                last++;
            active = (cur_components > NUM_COMP) ? NUM_COMP : cur_components;
            for (int c = 0; c < active; c++)
                component_mean(c, pred_first, last, res.ok[c], res.mean[c]);
        end
        expected_means.push_back(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(req_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= req_on_bus.mode;
                    s_tdata <= {5'd0, req_on_bus.vld[2], req_on_bus.vld[1], req_on_bus.vld[0],
                                req_on_bus.val[2], req_on_bus.val[1], req_on_bus.val[0],
                                req_on_bus.tstamp};
                    send_gap = pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (stalls_done != stalls_asked)
        begin
            stalls_done++;
            stall_left = 600;
            m_tready <= 1'b0;
        end
        else if (resp_gap > 0)
        begin
            resp_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            resp_gap = pick_gap();
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        window_mean_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_means.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response, expected none, actual %0h", $realtime,
                         m_tdata);
            end
            else
            begin
                w = expected_means.pop_front();
                check_field("ref_time", w.ref_time, m_tdata[31:0]);
                check_field("mean_a", 32'(w.mean[0]), 32'(m_tdata[55:32]));
                check_field("mean_b", 32'(w.mean[1]), 32'(m_tdata[79:56]));
                check_field("mean_c", 32'(w.mean[2]), 32'(m_tdata[103:80]));
                check_field("ok_a", 32'(w.ok[0]), 32'(m_tdata[104]));
                check_field("ok_b", 32'(w.ok[1]), 32'(m_tdata[105]));
                check_field("ok_c", 32'(w.ok[2]), 32'(m_tdata[106]));
            end
        end
    end

    task automatic push_req(input logic [1:0] mode, input longint t, input logic [23:0] a,
                            input logic [23:0] b, input logic [23:0] c,
                            input logic [2:0] vld);
        request_t r;
        r.mode = mode;
        r.tstamp = t[31:0];
        r.val[0] = a;
        r.val[1] = b;
        r.val[2] = c;
        r.vld[0] = vld[0];
        r.vld[1] = vld[1];
        r.vld[2] = vld[2];
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_means.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [HW_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_HALF_WINDOW)
            cur_half_window = data;
        else if (addr == REG_THRESHOLD)
            cur_threshold = data[11:0];
        else if (addr == REG_COMPONENTS)
            cur_components = data[1:0];
    endtask

    task automatic configure(input logic [30:0] hw, input logic [11:0] thr,
                             input logic [1:0] comps);
        wait_idle();
        write_reg(REG_HALF_WINDOW, hw);
        write_reg(REG_THRESHOLD, 31'(thr));
        write_reg(REG_COMPONENTS, 31'(comps));
    endtask

    function automatic logic [23:0] pick_value(input bit clustered, input logic [23:0] base);
        if (clustered && $urandom_range(0, 9) != 0)
            return base + 24'($urandom_range(0, 15)) - 24'd8;
        return 24'($urandom);
    endfunction

    function automatic logic [2:0] pick_valid();
        return {$urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
                $urandom_range(0, 19) != 0};
    endfunction

    task automatic random_traffic(input int count);
        longint      t;
        int          held;
        int          r;
        bit          clustered;
        logic [23:0] base;
        t = longint'($signed(32'($urandom_range(0, 4000)))) - 2000;
        if ($urandom_range(0, 4) == 0)
            t = longint'($signed($urandom()));
        held = 0;
        clustered = $urandom_range(0, 1);
        base = 24'($urandom);
        push_req(MODE_CLEAR, 0, 24'($urandom), 24'($urandom), 24'($urandom), pick_valid());
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (t > 64'sd2147483600)
                t = -64'sd2147483648;
            if (held >= 12 || r < 4)
            begin
                push_req(MODE_CLEAR, longint'($signed($urandom())), 24'($urandom),
                         24'($urandom), 24'($urandom), pick_valid());
                held = 0;
                clustered = $urandom_range(0, 1);
                base = 24'($urandom);
            end
            else if (r < 50)
            begin
                t += $urandom_range(0, 3);
                push_req(MODE_STORE, t, pick_value(clustered, base),
                         pick_value(clustered, base), pick_value(clustered, base), pick_valid());
                held++;
            end
            else if (r < 90)
            begin
                t += $urandom_range(0, 2);
                push_req(MODE_QUERY, t, 24'($urandom), 24'($urandom), 24'($urandom),
                         pick_valid());
            end
            else if (r < 95)
            begin
                push_req(2'd3, longint'($signed($urandom())), 24'($urandom), 24'($urandom),
                         24'($urandom), pick_valid());
            end
            else
            begin
                push_req($urandom_range(0, 1), longint'($signed($urandom())),
                         24'($urandom), 24'($urandom), 24'($urandom), pick_valid());
                held++;
            end
        end
    endtask

    initial
    begin
        logic [30:0] hw;
        logic [11:0] thr;
        logic [1:0]  comps;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        configure(31'd10, 12'd0, 2'd3);
        push_req(MODE_QUERY, 0, '0, '0, '0, 3'b111);
        push_req(MODE_STORE, 0, 24'h7fffff, 24'h800000, 24'h000000, 3'b111);
        push_req(MODE_QUERY, 0, '0, '0, '0, 3'b000);
        push_req(MODE_STORE, 5, 24'h800000, 24'h7fffff, 24'h000001, 3'b101);
        push_req(MODE_QUERY, 3, '0, '0, '0, 3'b000);
        push_req(2'd3, 4, 24'hffffff, 24'hffffff, 24'hffffff, 3'b111);
        push_req(MODE_CLEAR, 0, '0, '0, '0, 3'b000);
        push_req(MODE_QUERY, 0, '0, '0, '0, 3'b000);

        configure(31'd1000, 12'd1, 2'd2);
        push_req(MODE_STORE, 100, 24'd0, 24'd7, 24'd0, 3'b111);
        push_req(MODE_STORE, 101, 24'd10, 24'd7, 24'd0, 3'b111);
        push_req(MODE_QUERY, 100, '0, '0, '0, 3'b000);
        push_req(MODE_STORE, 110, 24'd5, 24'h800000, 24'd0, 3'b111);
        push_req(MODE_QUERY, 105, '0, '0, '0, 3'b000);
        push_req(MODE_CLEAR, 0, '0, '0, '0, 3'b000);

        configure(31'h7fffffff, 12'd4095, 2'd0);
        push_req(MODE_STORE, -64'sd2147483648, 24'd1, 24'd2, 24'd3, 3'b111);
        push_req(MODE_QUERY, 0, '0, '0, '0, 3'b000);
        configure(31'h7fffffff, 12'd4095, 2'd3);
        push_req(MODE_STORE, 64'sd2147483647, 24'd9, 24'hfffff0, 24'd3, 3'b111);
        push_req(MODE_QUERY, 64'sd2147483647, '0, '0, '0, 3'b000);
        push_req(MODE_QUERY, -64'sd2147483648, '0, '0, '0, 3'b000);
        push_req(MODE_CLEAR, 0, '0, '0, '0, 3'b000);

        configure(31'h7fffffff, 12'd300, 2'd3);
        for (int i = 0; i <= STORE_DEPTH; i++)
            push_req(MODE_STORE, i, 24'($urandom_range(0, 255)), 24'($urandom),
                     24'($urandom_range(0, 1000)), 3'b111);
        push_req(MODE_QUERY, 512, '0, '0, '0, 3'b000);
        push_req(MODE_CLEAR, 0, '0, '0, '0, 3'b000);

        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 5))
                0: hw = 31'd0;
                1: hw = 31'd1;
                2: hw = 31'h7fffffff;
                default: hw = 31'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 4))
                0: thr = 12'd0;
                1: thr = 12'd4095;
                2: thr = 12'($urandom_range(1, 4095));
                default: thr = 12'($urandom_range(128, 768));
            endcase
            comps = (ph == 0) ? 2'd0 : 2'($urandom_range(1, 3));
            configure(hw, thr, comps);
            if (ph == 4)
                stalls_asked++;
            random_traffic(58);
        end

        wait_idle();
        if (mismatches == 0)
            $display("** sigma_clipped_window_resampler_unit: PASSED **");
        else
            $display("** sigma_clipped_window_resampler_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("** sigma_clipped_window_resampler_unit: FAILED **");
        $finish;
    end

endmodule

[sigma_clipped_window_resampler_unit.f]
hdl/scwr_pkg.sv
hdl/scwr_div.sv
hdl/scwr_mul.sv
hdl/sigma_clipped_window_resampler_unit.sv
tb/sigma_clipped_window_resampler_unit_test.sv
